// ===== rtl/core/cha_pkg.sv =====
`timescale 1ns / 1ps
// Package for the compacting handle allocator: item types, codes and fixed sizes.
// Used by compacting_handle_allocator_unit; depends on nothing else.
package cha_pkg;

  localparam int unsigned SLOTS   = 4096;
  localparam int unsigned SLOT_W  = 12;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned MAX_RUN = 64;
  localparam int unsigned ELEM_W  = 64;
  localparam int unsigned WORDS   = 64;  // free-handle bitmap words of 64 bits
  localparam logic [CNT_W-1:0] SLOTS_CNT = 13'd4096;
  localparam logic [12:0] FRAG_RESET = 13'd2048;
  localparam logic [12:0] TAIL_RESET = 13'd128;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_BAD_HND = 2'd2,
    ST_BAD_IDX = 2'd3
  } status_e;

  typedef enum logic {
    CFG_FRAG = 1'b0,
    CFG_TAIL = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_HREAD,
    S_RDWAIT,
    S_CHECK,
    S_CRD,
    S_CHEAD,
    S_CLEN,
    S_CHSET,
    S_MVRD,
    S_MVWR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  run_length;
    logic [11:0] handle;
    logic [5:0]  slot_index;
    logic [63:0] write_data;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] handle_out;
    logic [11:0] run_start;
    logic [63:0] read_data;
    logic [12:0] free_total;
    logic [12:0] frontier;
    logic        compacted;
  } out_t;

  typedef struct packed {
    logic [6:0]  len;
    logic [11:0] start;
  } hent_t;

  typedef struct packed {
    logic        valid;
    logic [11:0] owner;
  } head_t;

endpackage

// ===== rtl/core/compacting_handle_allocator_unit.sv =====
`timescale 1ns / 1ps
// One item at a time: a new item is taken only in the idle state, after the last result has
// been registered; the handle table, free-handle bitmap and slot store have synchronous reads.
// A compaction, which an allocate or free may start, walks all 4096 slots and adds its walk to
// the item. After reset a clearing pass over all 4096 slots accepts no item.
module compacting_handle_allocator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cha_pkg::in_t       in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cha_pkg::out_t      out_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [12:0]        cfg_data_i
);

  cha_pkg::state_e state_q, state_d;
  cha_pkg::in_t    req_q;
  cha_pkg::out_t   out_q;
  logic            ovalid_q, ovalid_d;

  logic [1:0]  status_q, status_d;
  logic [11:0] hout_q, hout_d, rstart_q, rstart_d;
  logic [63:0] rdata_q, rdata_d;
  logic        did_q, did_d;
  logic [12:0] tail_q, tail_d, free_q, free_d;
  logic [12:0] fth_q, tth_q;
  logic [63:0] full_q, full_d;
  logic [11:0] clr_q, clr_d;
  logic [12:0] scan_q, scan_d, dest_q, dest_d;
  logic [11:0] mvh_q, mvh_d;
  logic [6:0]  mvn_q, mvn_d, mvi_q, mvi_d;
  logic [5:0]  wsel_q, wsel_d;

  // Memories.
  cha_pkg::hent_t hmem [cha_pkg::SLOTS];
  cha_pkg::head_t headmem [cha_pkg::SLOTS];
  logic [63:0]    dmem [cha_pkg::SLOTS];
  logic [63:0]    bmap [cha_pkg::WORDS];

  logic           hm_we;
  logic [11:0]    hm_wa, hm_ra;
  cha_pkg::hent_t hm_wd, hm_rd;
  logic           hd_we;
  logic [11:0]    hd_wa, hd_ra;
  cha_pkg::head_t hd_wd, hd_rd;
  logic           dm_we;
  logic [11:0]    dm_wa, dm_ra;
  logic [63:0]    dm_wd, dm_rd;
  logic           bm_we;
  logic [5:0]     bm_wa, bm_ra;
  logic [63:0]    bm_wd, bm_rd;

  always_ff @(posedge clk_i) begin
    if (hm_we) hmem[hm_wa] <= hm_wd;
    hm_rd <= hmem[hm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) headmem[hd_wa] <= hd_wd;
    hd_rd <= headmem[hd_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) dmem[dm_wa] <= dm_wd;
    dm_rd <= dmem[dm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) bmap[bm_wa] <= bm_wd;
    bm_rd <= bmap[bm_ra];
  end

  // Lowest bitmap word with a free handle, and lowest free handle within the read word.
  logic [5:0] w_free, b_free;
  logic       all_full;
  always_comb begin
    w_free = '0;
    b_free = '0;
    for (int i = cha_pkg::WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) w_free = 6'(i);
      if (!bm_rd[i]) b_free = 6'(i);
    end
    all_full = &full_q;
  end

  logic [12:0] tail_len, frag;
  logic        go_compact, len_bad, h_live;
  assign tail_len = cha_pkg::SLOTS_CNT - tail_q;
  assign frag     = (free_q >= tail_len) ? (free_q - tail_len) : '0;
  assign go_compact = (frag >= fth_q) && (tail_len <= tth_q) && (free_q != '0)
                      && (free_q != tail_len);
  assign len_bad = (req_q.run_length == '0) || (req_q.run_length > 7'(cha_pkg::MAX_RUN))
                   || (tail_len < 13'(req_q.run_length));
  assign h_live  = (hm_rd.len != '0);

  logic out_free;
  assign out_free = !ovalid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cha_pkg::S_CLEAR:  if (clr_q == 12'(cha_pkg::SLOTS - 1)) state_d = cha_pkg::S_IDLE;
      cha_pkg::S_IDLE:   if (in_valid_i) state_d = cha_pkg::S_DECODE;
      cha_pkg::S_DECODE: begin
        if (req_q.operation != cha_pkg::OP_ALLOC) state_d = cha_pkg::S_HREAD;
        else if (len_bad || all_full)             state_d = cha_pkg::S_DONE;
        else                                      state_d = cha_pkg::S_ALLOC;
      end
      cha_pkg::S_ALLOC:  state_d = cha_pkg::S_CHECK;
      cha_pkg::S_HREAD: begin
        if (!h_live)                                     state_d = cha_pkg::S_DONE;
        else if (req_q.operation == cha_pkg::OP_FREE)    state_d = cha_pkg::S_CHECK;
        else if (7'(req_q.slot_index) >= hm_rd.len)      state_d = cha_pkg::S_DONE;
        else if (req_q.operation == cha_pkg::OP_READ)    state_d = cha_pkg::S_RDWAIT;
        else                                             state_d = cha_pkg::S_DONE;
      end
      cha_pkg::S_RDWAIT: state_d = cha_pkg::S_DONE;
      cha_pkg::S_CHECK:  state_d = go_compact ? cha_pkg::S_CRD : cha_pkg::S_DONE;
      cha_pkg::S_CRD:    state_d = scan_q[12] ? cha_pkg::S_DONE : cha_pkg::S_CHEAD;
      cha_pkg::S_CHEAD:  state_d = hd_rd.valid ? cha_pkg::S_CLEN : cha_pkg::S_CRD;
      cha_pkg::S_CLEN:   state_d = (dest_q == scan_q) ? cha_pkg::S_CRD : cha_pkg::S_CHSET;
      cha_pkg::S_CHSET:  state_d = cha_pkg::S_MVRD;
      cha_pkg::S_MVRD:   state_d = cha_pkg::S_MVWR;
      cha_pkg::S_MVWR:   state_d = (mvi_q + 7'd1 == mvn_q) ? cha_pkg::S_CRD : cha_pkg::S_MVRD;
      cha_pkg::S_DONE:   if (out_free) state_d = cha_pkg::S_IDLE;
      default:           state_d = cha_pkg::S_CLEAR;
    endcase
  end

  // Datapath and memory controls.
  logic [63:0] bm_new;
  always_comb begin
    status_d = status_q;  hout_d = hout_q;  rstart_d = rstart_q;  rdata_d = rdata_q;
    did_d = did_q;  tail_d = tail_q;  free_d = free_q;  full_d = full_q;  clr_d = clr_q;
    scan_d = scan_q;  dest_d = dest_q;  mvh_d = mvh_q;  mvn_d = mvn_q;  mvi_d = mvi_q;
    wsel_d = wsel_q;
    hm_we = 1'b0;  hm_wa = '0;  hm_wd = '0;  hm_ra = req_q.handle;
    hd_we = 1'b0;  hd_wa = '0;  hd_wd = '0;  hd_ra = scan_q[11:0];
    dm_we = 1'b0;  dm_wa = '0;  dm_wd = '0;  dm_ra = '0;
    bm_we = 1'b0;  bm_wa = '0;  bm_wd = '0;  bm_ra = req_q.handle[11:6];
    bm_new = bm_rd;
    unique case (state_q)
      cha_pkg::S_CLEAR: begin
        hm_we = 1'b1;  hm_wa = clr_q;
        hd_we = 1'b1;  hd_wa = clr_q;
        bm_we = 1'b1;  bm_wa = clr_q[5:0];
        clr_d = clr_q + 12'd1;
      end
      cha_pkg::S_IDLE: begin
        status_d = cha_pkg::ST_OK;  rdata_d = '0;  did_d = 1'b0;
        rstart_d = '0;  hout_d = in_i.handle;
        if (in_i.operation == cha_pkg::OP_ALLOC) hout_d = '0;
      end
      cha_pkg::S_DECODE: begin
        wsel_d = w_free;
        // A free needs the bitmap word of its own handle instead.
        if (req_q.operation == cha_pkg::OP_ALLOC) bm_ra = w_free;
        if (req_q.operation == cha_pkg::OP_ALLOC && (len_bad || all_full))
          status_d = cha_pkg::ST_NO_ROOM;
      end
      cha_pkg::S_ALLOC: begin
        bm_new = bm_rd | (64'd1 << b_free);
        bm_we = 1'b1;  bm_wa = wsel_q;  bm_wd = bm_new;
        full_d[wsel_q] = &bm_new;
        hm_we = 1'b1;  hm_wa = {wsel_q, b_free};
        hm_wd = '{len: req_q.run_length, start: tail_q[11:0]};
        hd_we = 1'b1;  hd_wa = tail_q[11:0];  hd_wd = '{valid: 1'b1, owner: {wsel_q, b_free}};
        tail_d = tail_q + 13'(req_q.run_length);
        free_d = free_q - 13'(req_q.run_length);
        hout_d = {wsel_q, b_free};
        rstart_d = tail_q[11:0];
      end
      cha_pkg::S_HREAD: begin
        rstart_d = hm_rd.start;
        if (!h_live) begin
          status_d = cha_pkg::ST_BAD_HND;
        end else if (req_q.operation == cha_pkg::OP_FREE) begin
          hm_we = 1'b1;  hm_wa = req_q.handle;  hm_wd = '{len: '0, start: hm_rd.start};
          bm_new = bm_rd & ~(64'd1 << req_q.handle[5:0]);
          bm_we = 1'b1;  bm_wa = req_q.handle[11:6];  bm_wd = bm_new;
          full_d[req_q.handle[11:6]] = 1'b0;
          hd_we = 1'b1;  hd_wa = hm_rd.start;  hd_wd = '0;
          if ({1'b0, hm_rd.start} + 13'(hm_rd.len) == tail_q) tail_d = {1'b0, hm_rd.start};
          free_d = free_q + 13'(hm_rd.len);
        end else if (7'(req_q.slot_index) >= hm_rd.len) begin
          status_d = cha_pkg::ST_BAD_IDX;
        end else begin
          dm_ra = hm_rd.start + 12'(req_q.slot_index);
          dm_wa = dm_ra;
          dm_wd = req_q.write_data;
          dm_we = (req_q.operation == cha_pkg::OP_WRITE);
        end
      end
      cha_pkg::S_RDWAIT: rdata_d = dm_rd;
      cha_pkg::S_CHECK: begin
        scan_d = '0;
        dest_d = '0;
      end
      cha_pkg::S_CRD: begin
        if (scan_q[12]) begin
          tail_d = dest_q;
          did_d  = 1'b1;
        end
      end
      cha_pkg::S_CHEAD: begin
        hm_ra = hd_rd.owner;
        mvh_d = hd_rd.owner;
        if (!hd_rd.valid) scan_d = scan_q + 13'd1;
      end
      cha_pkg::S_CLEN: begin
        mvn_d = (hm_rd.len == '0) ? 7'd1 : hm_rd.len;
        mvi_d = '0;
        hm_we = 1'b1;  hm_wa = mvh_q;  hm_wd = '{len: hm_rd.len, start: dest_q[11:0]};
        if (req_q.operation == cha_pkg::OP_ALLOC && mvh_q == hout_q) rstart_d = dest_q[11:0];
        if (dest_q == scan_q) begin
          scan_d = scan_q + 13'(mvn_d);
          dest_d = dest_q + 13'(mvn_d);
        end else begin
          hd_we = 1'b1;  hd_wa = scan_q[11:0];  hd_wd = '0;
        end
      end
      cha_pkg::S_CHSET: begin
        hd_we = 1'b1;  hd_wa = dest_q[11:0];  hd_wd = '{valid: 1'b1, owner: mvh_q};
      end
      cha_pkg::S_MVRD: dm_ra = scan_q[11:0] + 12'(mvi_q);
      cha_pkg::S_MVWR: begin
        dm_we = 1'b1;  dm_wa = dest_q[11:0] + 12'(mvi_q);  dm_wd = dm_rd;
        mvi_d = mvi_q + 7'd1;
        if (mvi_d == mvn_q) begin
          scan_d = scan_q + 13'(mvn_q);
          dest_d = dest_q + 13'(mvn_q);
        end
      end
      cha_pkg::S_DONE: ;
      default: ;
    endcase
  end

  // Output register: a finished result waits here while the next transfer comes in.
  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    if (state_q == cha_pkg::S_DONE && out_free) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cha_pkg::S_IDLE && in_valid_i) req_q <= in_i;
    if (state_q == cha_pkg::S_DONE && out_free) begin
      out_q <= '{status: status_q, handle_out: hout_q, run_start: rstart_q,
                 read_data: rdata_q, free_total: free_q, frontier: tail_q,
                 compacted: did_q};
    end
    status_q <= status_d;  hout_q <= hout_d;  rstart_q <= rstart_d;  rdata_q <= rdata_d;
    did_q <= did_d;  scan_q <= scan_d;  dest_q <= dest_d;  mvh_q <= mvh_d;
    mvn_q <= mvn_d;  mvi_q <= mvi_d;  wsel_q <= wsel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cha_pkg::S_CLEAR;
      ovalid_q <= 1'b0;
      tail_q   <= '0;
      free_q   <= cha_pkg::SLOTS_CNT;
      full_q   <= '0;
      clr_q    <= '0;
      fth_q    <= cha_pkg::FRAG_RESET;
      tth_q    <= cha_pkg::TAIL_RESET;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      tail_q   <= tail_d;
      free_q   <= free_d;
      full_q   <= full_d;
      clr_q    <= clr_d;
      if (cfg_we_i) begin
        unique case (cha_pkg::cfg_idx_e'(cfg_index_i))
          cha_pkg::CFG_FRAG: fth_q <= cfg_data_i;
          cha_pkg::CFG_TAIL: tth_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign in_stall_o  = (state_q != cha_pkg::S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

  // The free tail is always part of the free count.
  a_tail_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q >= tail_len) else $error("free count below tail length");
  a_frontier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= cha_pkg::SLOTS_CNT) else $error("frontier beyond store");
  // Compaction never writes ahead of the slot that it scans.
  a_pack_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cha_pkg::S_CHEAD || state_q == cha_pkg::S_MVWR) |-> dest_q <= scan_q)
    else $error("compaction destination ahead of scan");
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == cha_pkg::S_DONE))
    else $error("result without finished item");

endmodule
